// File: rtl/core/saa_pkg.sv
// ----------------------------------------------------------------------------
// saa_pkg
// Shared types and constants of the skyline atlas allocator.
// ----------------------------------------------------------------------------
package saa_pkg;

  localparam int ATLAS_WIDTH_DEF  = 128;
  localparam int ATLAS_HEIGHT_DEF = 128;
  localparam int ATLAS_COUNT_DEF  = 32;

  localparam int CELL_SHIFT = 4;
  localparam int EXTENT_W   = 12;
  localparam int SIZE_W     = EXTENT_W - CELL_SHIFT + 1;

  localparam int STATUS_W = 2;
  localparam int ATLAS_W  = 5;
  localparam int POS_W    = 7;

  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_TOO_LARGE = 2'd1,
    STAT_EXHAUSTED = 2'd2
  } status_e;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CLEAR  = 7'b0000010,
    S_SEED   = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_DECIDE = 7'b0010000,
    S_RAISE  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  typedef struct packed {
    status_e            status;
    logic [ATLAS_W-1:0] atlas_index;
    logic [POS_W-1:0]   x_pos;
    logic [POS_W-1:0]   y_pos;
  } res_t;

endpackage

// File: rtl/core/skyline_atlas_allocator.sv
// Begin clears the height RAM. Allocate seeds, scans, decides and raises the
// w placed columns, with a clear and a second scan when the atlas advances; a
// too large request goes straight to the done state. Scan reads one column per
// cycle from the height RAM. One transaction at a time.
// Reset: control clears; the height RAM is swept to zero after reset, with
// in_ready_o low during the sweep.
// ----------------------------------------------------------------------------
// skyline_atlas_allocator
// Skyline rectangle packer over a sequence of square atlases.
// ----------------------------------------------------------------------------
module skyline_atlas_allocator #(
  parameter int ATLAS_WIDTH  = saa_pkg::ATLAS_WIDTH_DEF,
  parameter int ATLAS_HEIGHT = saa_pkg::ATLAS_HEIGHT_DEF,
  parameter int ATLAS_COUNT  = saa_pkg::ATLAS_COUNT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         cmd_i,
  input  logic [saa_pkg::EXTENT_W-1:0] extent_s_i,
  input  logic [saa_pkg::EXTENT_W-1:0] extent_t_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [saa_pkg::STATUS_W-1:0] status_o,
  output logic [saa_pkg::ATLAS_W-1:0]  atlas_index_o,
  output logic [saa_pkg::POS_W-1:0]    x_pos_o,
  output logic [saa_pkg::POS_W-1:0]    y_pos_o
);

  import saa_pkg::*;

  localparam int CW = $clog2(ATLAS_WIDTH);
  localparam int HW = $clog2(ATLAS_HEIGHT + 1);

  logic          mem_we;
  logic [CW-1:0] mem_waddr;
  logic [HW-1:0] mem_wdata;
  logic [CW-1:0] mem_raddr;
  logic [HW-1:0] mem_rdata;

  logic res_valid;
  logic res_ready;
  res_t res;

  logic out_valid_q, out_valid_d;
  res_t out_q;

  saa_height_ram #(
    .DEPTH  (ATLAS_WIDTH),
    .DATA_W (HW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  saa_ctrl #(
    .ATLAS_WIDTH  (ATLAS_WIDTH),
    .ATLAS_HEIGHT (ATLAS_HEIGHT),
    .ATLAS_COUNT  (ATLAS_COUNT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .extent_s_i  (extent_s_i),
    .extent_t_i  (extent_t_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign atlas_index_o = out_q.atlas_index;
  assign x_pos_o       = out_q.x_pos;
  assign y_pos_o       = out_q.y_pos;

endmodule

// File: rtl/core/saa_height_ram.sv
// ----------------------------------------------------------------------------
// saa_height_ram
// Column height store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module saa_height_ram #(
  parameter int DEPTH  = 128,
  parameter int DATA_W = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/saa_ctrl.sv
// ----------------------------------------------------------------------------
// saa_ctrl
// Sequencer: clear pass, skyline scan over the height store, column raise.
// ----------------------------------------------------------------------------
module saa_ctrl #(
  parameter int ATLAS_WIDTH  = 128,
  parameter int ATLAS_HEIGHT = 128,
  parameter int ATLAS_COUNT  = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   cmd_i,
  input  logic [saa_pkg::EXTENT_W-1:0]           extent_s_i,
  input  logic [saa_pkg::EXTENT_W-1:0]           extent_t_i,
  output logic                                   res_valid_o,
  input  logic                                   res_ready_i,
  output saa_pkg::res_t                          res_o,
  output logic                                   mem_we_o,
  output logic [$clog2(ATLAS_WIDTH)-1:0]         mem_waddr_o,
  output logic [$clog2(ATLAS_HEIGHT+1)-1:0]      mem_wdata_o,
  output logic [$clog2(ATLAS_WIDTH)-1:0]         mem_raddr_o,
  input  logic [$clog2(ATLAS_HEIGHT+1)-1:0]      mem_rdata_i
);

  import saa_pkg::*;

  localparam int CW   = $clog2(ATLAS_WIDTH);
  localparam int IW   = CW + 1;
  localparam int HW   = $clog2(ATLAS_HEIGHT + 1);
  localparam int ACW  = (ATLAS_COUNT > 1) ? $clog2(ATLAS_COUNT) : 1;
  localparam int MW0  = (IW > SIZE_W) ? IW : SIZE_W;
  localparam int MW1  = (MW0 > HW) ? MW0 : HW;
  localparam int CMPW = MW1 + 2;

  state_e            state_q, state_d;
  logic              boot_q, boot_d;
  logic              op_begin_q, op_begin_d;
  logic              retry_q, retry_d;
  logic [SIZE_W-1:0] w_q, w_d;
  logic [SIZE_W-1:0] h_q, h_d;
  logic [IW-1:0]     i_q, i_d;
  logic [SIZE_W-1:0] j_q, j_d;
  logic [HW-1:0]     top_q, top_d;
  logic [HW-1:0]     best_q, best_d;
  logic [CW-1:0]     bx_q, bx_d;
  logic              found_q, found_d;
  logic [CW-1:0]     k_q, k_d;
  logic [ACW-1:0]    atlas_q, atlas_d;
  status_e           stat_q, stat_d;
  logic [CW-1:0]     rx_q, rx_d;
  logic [HW-1:0]     ry_q, ry_d;

  logic [SIZE_W-1:0] w_in, h_in;
  logic [HW-1:0]     top_n;
  logic [CMPW-1:0]   fit_sum;
  logic [CW+POS_W-1:0]    x_ext;
  logic [HW+POS_W-1:0]    y_ext;
  logic [ACW+ATLAS_W-1:0] a_ext;

  assign w_in = {1'b0, extent_s_i[EXTENT_W-1:CELL_SHIFT]} + SIZE_W'(1);
  assign h_in = {1'b0, extent_t_i[EXTENT_W-1:CELL_SHIFT]} + SIZE_W'(1);
  assign top_n = (mem_rdata_i > top_q) ? mem_rdata_i : top_q;
  assign fit_sum = CMPW'(best_q) + CMPW'(h_q);

  always_comb begin
    state_d    = state_q;
    boot_d     = boot_q;
    op_begin_d = op_begin_q;
    retry_d    = retry_q;
    w_d        = w_q;
    h_d        = h_q;
    i_d        = i_q;
    j_d        = j_q;
    top_d      = top_q;
    best_d     = best_q;
    bx_d       = bx_q;
    found_d    = found_q;
    k_d        = k_q;
    atlas_d    = atlas_q;
    stat_d     = stat_q;
    rx_d       = rx_q;
    ry_d       = ry_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = k_q;
    mem_wdata_o = '0;
    res_valid_o = 1'b0;
    in_ready_o  = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          stat_d = STAT_OK;
          rx_d   = '0;
          ry_d   = '0;
          if (cmd_i == CMD_BEGIN) begin
            op_begin_d = 1'b1;
            atlas_d    = '0;
            k_d        = '0;
            state_d    = S_CLEAR;
          end else begin
            op_begin_d = 1'b0;
            w_d        = w_in;
            h_d        = h_in;
            if ((CMPW'(w_in) >= CMPW'(ATLAS_WIDTH)) ||
                (CMPW'(h_in) > CMPW'(ATLAS_HEIGHT))) begin
              stat_d  = STAT_TOO_LARGE;
              state_d = S_DONE;
            end else begin
              retry_d = 1'b0;
              i_d     = '0;
              j_d     = '0;
              top_d   = '0;
              best_d  = HW'(ATLAS_HEIGHT);
              found_d = 1'b0;
              state_d = S_SEED;
            end
          end
        end
      end

      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = k_q;
        mem_wdata_o = '0;
        if (k_q == CW'(ATLAS_WIDTH - 1)) begin
          k_d = '0;
          if (boot_q) begin
            boot_d  = 1'b0;
            state_d = S_IDLE;
          end else if (op_begin_q) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SEED;
          end
        end else begin
          k_d = k_q + CW'(1);
        end
      end

      S_SEED: begin
        state_d = S_SCAN;
      end

      S_SCAN: begin
        if (mem_rdata_i >= best_q) begin
          i_d   = IW'(CMPW'(i_q) + CMPW'(j_q) + CMPW'(1));
          j_d   = '0;
          top_d = '0;
        end else if (j_q + SIZE_W'(1) == w_q) begin
          best_d  = top_n;
          bx_d    = i_q[CW-1:0];
          found_d = 1'b1;
          i_d     = i_q + IW'(1);
          j_d     = '0;
          top_d   = '0;
        end else begin
          j_d   = j_q + SIZE_W'(1);
          top_d = top_n;
        end
        if (CMPW'(i_d) + CMPW'(w_q) >= CMPW'(ATLAS_WIDTH)) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (found_q && (fit_sum <= CMPW'(ATLAS_HEIGHT))) begin
          stat_d  = STAT_OK;
          rx_d    = bx_q;
          ry_d    = best_q;
          k_d     = '0;
          state_d = S_RAISE;
        end else if (retry_q) begin
          stat_d  = STAT_TOO_LARGE;
          rx_d    = '0;
          ry_d    = '0;
          state_d = S_DONE;
        end else if (CMPW'(atlas_q) + CMPW'(1) >= CMPW'(ATLAS_COUNT)) begin
          stat_d  = STAT_EXHAUSTED;
          rx_d    = '0;
          ry_d    = '0;
          state_d = S_DONE;
        end else begin
          atlas_d = atlas_q + ACW'(1);
          retry_d = 1'b1;
          i_d     = '0;
          j_d     = '0;
          top_d   = '0;
          best_d  = HW'(ATLAS_HEIGHT);
          found_d = 1'b0;
          k_d     = '0;
          state_d = S_CLEAR;
        end
      end

      S_RAISE: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = rx_q + k_q;
        mem_wdata_o = HW'(CMPW'(ry_q) + CMPW'(h_q));
        if (CMPW'(k_q) + CMPW'(1) == CMPW'(w_q)) begin
          state_d = S_DONE;
        end else begin
          k_d = k_q + CW'(1);
        end
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign mem_raddr_o = CW'(CMPW'(i_d) + CMPW'(j_d));

  assign x_ext = {{POS_W{1'b0}}, rx_q};
  assign y_ext = {{POS_W{1'b0}}, ry_q};
  assign a_ext = {{ATLAS_W{1'b0}}, atlas_q};

  always_comb begin
    res_o.status      = stat_q;
    res_o.atlas_index = a_ext[ATLAS_W-1:0];
    res_o.x_pos       = x_ext[POS_W-1:0];
    res_o.y_pos       = y_ext[POS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      boot_q     <= 1'b1;
      op_begin_q <= 1'b0;
      retry_q    <= 1'b0;
      k_q        <= '0;
      atlas_q    <= '0;
    end else begin
      state_q    <= state_d;
      boot_q     <= boot_d;
      op_begin_q <= op_begin_d;
      retry_q    <= retry_d;
      k_q        <= k_d;
      atlas_q    <= atlas_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q     <= w_d;
    h_q     <= h_d;
    i_q     <= i_d;
    j_q     <= j_d;
    top_q   <= top_d;
    best_q  <= best_d;
    bx_q    <= bx_d;
    found_q <= found_d;
    stat_q  <= stat_d;
    rx_q    <= rx_d;
    ry_q    <= ry_d;
  end

endmodule

// File: tb/skyline_atlas_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// skyline_atlas_allocator_tb
// Self-checking bench for the skyline atlas packer. A queued driver offers
// begin and allocate transactions in random bursts. A predictor keeps its own
// column heights and atlas number and computes each placement. A monitor
// compares every result field against the oldest predicted placement while
// the receiver stalls on its own pattern, including one long hold-off.
// ----------------------------------------------------------------------------
module skyline_atlas_allocator_tb;

  localparam int ATLAS_WIDTH  = saa_pkg::ATLAS_WIDTH_DEF;
  localparam int ATLAS_HEIGHT = saa_pkg::ATLAS_HEIGHT_DEF;
  localparam int ATLAS_COUNT  = saa_pkg::ATLAS_COUNT_DEF;
  localparam int EW           = saa_pkg::EXTENT_W;
  localparam int RANDOM_ITEMS = 650;

  typedef struct packed {
    logic          cmd;
    logic [EW-1:0] es;
    logic [EW-1:0] et;
  } alloc_req_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  logic                         cmd_i       = saa_pkg::CMD_BEGIN;
  logic [EW-1:0]                extent_s_i  = '0;
  logic [EW-1:0]                extent_t_i  = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [saa_pkg::STATUS_W-1:0] status_o;
  logic [saa_pkg::ATLAS_W-1:0]  atlas_index_o;
  logic [saa_pkg::POS_W-1:0]    x_pos_o;
  logic [saa_pkg::POS_W-1:0]    y_pos_o;

  skyline_atlas_allocator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .extent_s_i   (extent_s_i),
    .extent_t_i   (extent_t_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .atlas_index_o(atlas_index_o),
    .x_pos_o      (x_pos_o),
    .y_pos_o      (y_pos_o)
  );

  always #5 clk_i = ~clk_i;

  alloc_req_t    pending_q[$];
  saa_pkg::res_t placement_q[$];
  alloc_req_t    drv_req;
  saa_pkg::res_t want;

  logic [7:0] col_height [ATLAS_WIDTH];
  logic [5:0] atlas_cnt;

  int total_items;
  int issued_cnt   = 0;
  int drained_cnt  = 0;
  int mismatch_cnt = 0;
  int burst_left   = 0;
  int gap_left     = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  int pat_left     = 0;
  logic [31:0] ready_pat;

  // --------------------------------------------------------------------------
  // Placement predictor
  // --------------------------------------------------------------------------
  function automatic bit find_lowest_fit(input int w, input int h,
                                         output int px, output int py);
    int best;
    int bx;
    int top;
    bit found;
    bit ok;
    best  = ATLAS_HEIGHT;
    bx    = 0;
    found = 1'b0;
    px    = 0;
    py    = 0;
    if (w >= ATLAS_WIDTH) return 1'b0;
    for (int i = 0; i + w < ATLAS_WIDTH; i++) begin
      top = 0;
      ok  = 1'b1;
      for (int j = 0; j < w && ok; j++) begin
        if (col_height[i+j] >= best) ok = 1'b0;
        else if (col_height[i+j] > top) top = int'(col_height[i+j]);
      end
      if (ok) begin
        best  = top;
        bx    = i;
        found = 1'b1;
      end
    end
    if (!found || best + h > ATLAS_HEIGHT) return 1'b0;
    px = bx;
    py = best;
    return 1'b1;
  endfunction

  task automatic clear_heights();
    foreach (col_height[i]) col_height[i] = '0;
  endtask

  task automatic raise_columns(input int x, input int y, input int w, input int h);
    for (int i = 0; i < w && x + i < ATLAS_WIDTH; i++) col_height[x+i] = 8'(y + h);
  endtask

  task automatic pack_rect(input alloc_req_t r);
    saa_pkg::res_t res;
    int w;
    int h;
    int x;
    int y;
    res = '0;
    x   = 0;
    y   = 0;
    if (r.cmd == saa_pkg::CMD_BEGIN) begin
      clear_heights();
      atlas_cnt = '0;
    end else begin
      w = (int'(r.es) >> saa_pkg::CELL_SHIFT) + 1;
      h = (int'(r.et) >> saa_pkg::CELL_SHIFT) + 1;
      if (w >= ATLAS_WIDTH || h > ATLAS_HEIGHT) begin
        res.status = saa_pkg::STAT_TOO_LARGE;
      end else if (find_lowest_fit(w, h, x, y)) begin
        raise_columns(x, y, w, h);
      end else if (atlas_cnt + 1 >= ATLAS_COUNT) begin
        res.status = saa_pkg::STAT_EXHAUSTED;
        x = 0;
        y = 0;
      end else begin
        atlas_cnt = 6'(atlas_cnt + 1);
        clear_heights();
        if (find_lowest_fit(w, h, x, y)) begin
          raise_columns(x, y, w, h);
        end else begin
          res.status = saa_pkg::STAT_TOO_LARGE;
          x = 0;
          y = 0;
        end
      end
      res.atlas_index = atlas_cnt[saa_pkg::ATLAS_W-1:0];
      res.x_pos       = x[saa_pkg::POS_W-1:0];
      res.y_pos       = y[saa_pkg::POS_W-1:0];
    end
    placement_q.push_back(res);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic void queue_begin(input logic [EW-1:0] es, input logic [EW-1:0] et);
    pending_q.push_back('{cmd: saa_pkg::CMD_BEGIN, es: es, et: et});
  endfunction

  function automatic void queue_alloc(input logic [EW-1:0] es, input logic [EW-1:0] et);
    pending_q.push_back('{cmd: saa_pkg::CMD_ALLOC, es: es, et: et});
  endfunction

  // extent whose cell size lies in [lo, hi], with random sub-cell bits
  function automatic logic [EW-1:0] cells_extent(input int lo, input int hi);
    int cells;
    cells = $urandom_range(hi, lo);
    return EW'(((cells - 1) << saa_pkg::CELL_SHIFT) | $urandom_range(15, 0));
  endfunction

  task automatic build_stimulus();
    int kind;
    int n;
    int stop_at;
    // before any begin, extremes, advance, too large
    queue_alloc(12'd0, 12'd0);
    queue_begin(12'hFFF, 12'hFFF);
    queue_alloc(12'd2031, 12'd2047);
    queue_alloc(12'd0, 12'd0);
    queue_alloc(12'd2032, 12'd0);
    queue_alloc(12'd0, 12'd2048);
    queue_alloc(12'hFFF, 12'hFFF);
    queue_alloc(12'd15, 12'd15);
    queue_alloc(12'd53, 12'd128);
    queue_alloc(12'd16, 12'd0);
    queue_alloc(12'd32, 12'd64);
    // fits the columns but not the remaining height
    queue_begin(12'd0, 12'd0);
    queue_alloc(12'd2016, 12'd1584);
    queue_alloc(12'd0, 12'd432);
    queue_alloc(12'd0, 12'd448);
    queue_alloc(12'd2031, 12'd2047);
    // equal rows, leftmost wins
    queue_begin(12'hAAA, 12'h555);
    queue_alloc(12'd144, 12'd64);
    queue_alloc(12'd144, 12'd64);
    queue_alloc(12'h555, 12'h0AA);
    queue_alloc(12'h0AA, 12'h555);

    stop_at = RANDOM_ITEMS - 30;
    // fill every atlas until exhausted
    queue_begin(EW'($urandom), EW'($urandom));
    repeat (35) queue_alloc(12'd2016 | EW'($urandom_range(15, 0)),
                            12'd2032 | EW'($urandom_range(15, 0)));
    while (pending_q.size() < stop_at) begin
      kind = $urandom_range(9, 0);
      if (kind < 4) begin
        queue_begin(EW'($urandom), EW'($urandom));
        n = $urandom_range(70, 30);
        repeat (n) queue_alloc(cells_extent(24, 127), cells_extent(24, 128));
      end else if (kind < 8) begin
        if ($urandom_range(1, 0)) queue_begin(EW'($urandom), EW'($urandom));
        n = $urandom_range(40, 10);
        repeat (n) queue_alloc(cells_extent(1, 16), cells_extent(1, 16));
      end else begin
        n = $urandom_range(5, 1);
        repeat (n) begin
          if ($urandom_range(7, 0) == 0) queue_begin(EW'($urandom), EW'($urandom));
          else queue_alloc(EW'($urandom), EW'($urandom));
        end
      end
    end
    total_items = pending_q.size();
  endtask

  // --------------------------------------------------------------------------
  // Driver
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cmd_i      <= saa_pkg::CMD_BEGIN;
      extent_s_i <= '0;
      extent_t_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        pack_rect(drv_req);
        issued_cnt++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          drv_req = pending_q.pop_front();
          cmd_i      <= drv_req.cmd;
          extent_s_i <= drv_req.es;
          extent_t_i <= drv_req.et;
          in_valid_i <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(24, 1);
            gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(15, 1);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver back-pressure: random pattern plus one long hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) drained_cnt++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_done && drained_cnt >= 120) begin
        hold_done = 1'b1;
        hold_left = 600;
        out_ready_i <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat_left = $urandom_range(96, 16);
          case ($urandom_range(3, 0))
            0: ready_pat = '1;
            1: ready_pat = $urandom;
            2: ready_pat = $urandom | $urandom;
            default: ready_pat = $urandom & $urandom;
          endcase
        end
        out_ready_i <= ready_pat[0];
        ready_pat = {ready_pat[0], ready_pat[31:1]};
        pat_left--;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (placement_q.size() == 0) begin
        $error("result with no placement pending");
        mismatch_cnt++;
      end else begin
        want = placement_q.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          mismatch_cnt++;
        end
        if (atlas_index_o !== want.atlas_index) begin
          $error("atlas_index: expected %0d, actual %0d", want.atlas_index, atlas_index_o);
          mismatch_cnt++;
        end
        if (x_pos_o !== want.x_pos) begin
          $error("x_pos: expected %0d, actual %0d", want.x_pos, x_pos_o);
          mismatch_cnt++;
        end
        if (y_pos_o !== want.y_pos) begin
          $error("y_pos: expected %0d, actual %0d", want.y_pos, y_pos_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing
  // --------------------------------------------------------------------------
  initial begin
    clear_heights();
    atlas_cnt = '0;
    build_stimulus();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (issued_cnt == total_items);
    wait (placement_q.size() == 0);
    repeat (300) @(posedge clk_i);
    if (mismatch_cnt == 0 && placement_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(250_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/saa_pkg.sv
rtl/core/saa_height_ram.sv
rtl/core/saa_ctrl.sv
rtl/core/skyline_atlas_allocator.sv
tb/skyline_atlas_allocator_tb.sv
